// File: design/kcsm_pkg.sv
// Shared types and constants for the hotkey chord matcher.
// Used by kcsm_cell and key_chord_shortcut_matcher_top; no dependencies.
package kcsm_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEYS_DEF     = 6;
  localparam int NUM_PRESSED  = 6;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_KEY    = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_ENTRY = 2'd1;
  localparam logic [1:0] ST_BAD_COUNT = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT  = 2'd3;

  typedef logic [NUM_PRESSED-1:0][7:0] key_arr_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] entry;
    logic       enable;
    logic [7:0] count;
    logic [7:0] key_slot;
    logic [7:0] key_value;
    logic [7:0] pressed_0;
    logic [7:0] pressed_1;
    logic [7:0] pressed_2;
    logic [7:0] pressed_3;
    logic [7:0] pressed_4;
    logic [7:0] pressed_5;
  } kcsm_in_t;

  typedef struct packed {
    logic       found;
    logic [3:0] found_entry;
    logic [1:0] status;
  } kcsm_out_t;

  // Table write broadcast to every cell; enables are already qualified.
  typedef struct packed {
    logic       hdr_we;
    logic       key_we;
    logic [7:0] entry;
    logic       enable;
    logic [7:0] count;
    logic [7:0] slot;
    logic [7:0] value;
  } kcsm_wr_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic       valid;
    logic       found;
    logic [3:0] found_entry;
  } kcsm_tok_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_WAIT
  } kcsm_state_t;

endpackage

// File: design/kcsm_cell.sv
// One table entry of the chord matcher: enable, key count, stored keys,
// plus one stage of the search token chain. Depends on kcsm_pkg.
module kcsm_cell #(
  parameter int CELL_IDX       = 0,
  parameter int KEYS_PER_ENTRY = kcsm_pkg::KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kcsm_pkg::kcsm_wr_t  wr,
  input  logic [7:0]          q_count,
  input  kcsm_pkg::key_arr_t  q_keys,
  input  kcsm_pkg::kcsm_tok_t tok_in,
  output kcsm_pkg::kcsm_tok_t tok_out
);

  localparam int CW = $clog2(KEYS_PER_ENTRY + 1);

  logic                           en_r, en_nxt;
  logic [CW-1:0]                  cnt_r, cnt_nxt;
  logic [KEYS_PER_ENTRY-1:0][7:0] keys_r, keys_nxt;
  kcsm_pkg::kcsm_tok_t            tok_r, tok_nxt;
  logic                           sel;
  logic [KEYS_PER_ENTRY-1:0]      present;
  logic                           all_ok;
  logic                           hit;

  assign sel = (wr.entry == 8'(CELL_IDX));

  always_comb begin
    en_nxt   = en_r;
    cnt_nxt  = cnt_r;
    keys_nxt = keys_r;
    if (wr.hdr_we && sel) begin
      en_nxt  = wr.enable;
      cnt_nxt = CW'(wr.count);
    end
    for (int s = 0; s < KEYS_PER_ENTRY; s++) begin
      if (wr.key_we && sel && (wr.slot == 8'(s))) begin
        keys_nxt[s] = wr.value;
      end
    end
  end

  // set test: every live stored key must appear among the live pressed keys
  always_comb begin
    all_ok = 1'b1;
    for (int s = 0; s < KEYS_PER_ENTRY; s++) begin
      present[s] = 1'b0;
      for (int p = 0; p < KEYS_PER_ENTRY; p++) begin
        if ((8'(p) < q_count) && (q_keys[p] == keys_r[s])) begin
          present[s] = 1'b1;
        end
      end
      if ((8'(s) < 8'(cnt_r)) && !present[s]) begin
        all_ok = 1'b0;
      end
    end
  end

  assign hit = en_r && (q_count == 8'(cnt_r)) && all_ok;

  always_comb begin
    tok_nxt = tok_in;
    if (!tok_in.found && hit) begin
      tok_nxt.found       = 1'b1;
      tok_nxt.found_entry = 4'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      cnt_r       <= '0;
      keys_r      <= '0;
      tok_r.valid <= 1'b0;
    end else begin
      en_r        <= en_nxt;
      cnt_r       <= cnt_nxt;
      keys_r      <= keys_nxt;
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.found       <= tok_nxt.found;
    tok_r.found_entry <= tok_nxt.found_entry;
  end

  assign tok_out = tok_r;

endmodule

// File: design/key_chord_shortcut_matcher_top.sv
// Top level of the hotkey chord matcher: handshakes, write checks, query
// sequencing and the chain of kcsm_cell entries. Depends on kcsm_pkg, kcsm_cell.
//
//  channel  | ports                        | moves
//  ---------+------------------------------+-------------------------------
//  input    | in_valid, in_ready, in_data  | header write, key write, query
//  output   | out_valid, out_ready, out_data| one result item per input item
//
// Writes and unused kinds show their result the next cycle. A query walks
// the cell chain one entry per cycle; its result waits in hold_r while the
// output register is busy. One query walks at a time. A query may be
// accepted while a result still waits; writes wait for the output register
// to free. Reset is synchronous and clears the whole table.
module key_chord_shortcut_matcher_top #(
  parameter int ENTRIES        = kcsm_pkg::ENTRIES_DEF,
  parameter int KEYS_PER_ENTRY = kcsm_pkg::KEYS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kcsm_pkg::kcsm_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kcsm_pkg::kcsm_out_t out_data
);

  kcsm_pkg::kcsm_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kcsm_pkg::kcsm_out_t   out_r, out_nxt;
  kcsm_pkg::kcsm_out_t   hold_r, hold_nxt;
  logic                  start_r, start_nxt;
  logic [7:0]            q_count_r;
  kcsm_pkg::key_arr_t    q_keys_r;
  kcsm_pkg::kcsm_wr_t    wr;
  kcsm_pkg::kcsm_tok_t   tok [ENTRIES+1];
  logic                  accept;
  logic                  is_query;
  logic                  out_free;
  logic                  entry_ok;
  logic                  count_ok;
  logic                  slot_ok;

  assign is_query = (in_data.kind == kcsm_pkg::KIND_QUERY);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == kcsm_pkg::FSM_IDLE) && (out_free || is_query);
  assign accept   = in_valid && in_ready;

  assign entry_ok = ({1'b0, in_data.entry} < 9'(ENTRIES));
  assign count_ok = ({1'b0, in_data.count} <= 9'(KEYS_PER_ENTRY));
  assign slot_ok  = ({1'b0, in_data.key_slot} < 9'(KEYS_PER_ENTRY));

  always_comb begin
    wr.hdr_we = accept && (in_data.kind == kcsm_pkg::KIND_HEADER) && entry_ok && count_ok;
    wr.key_we = accept && (in_data.kind == kcsm_pkg::KIND_KEY) && entry_ok && slot_ok;
    wr.entry  = in_data.entry;
    wr.enable = in_data.enable;
    wr.count  = in_data.count;
    wr.slot   = in_data.key_slot;
    wr.value  = in_data.key_value;
  end

  assign tok[0] = '{valid: start_r, found: 1'b0, found_entry: 4'd0};

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kcsm_cell #(
      .CELL_IDX       (i),
      .KEYS_PER_ENTRY (KEYS_PER_ENTRY)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr),
      .q_count (q_count_r),
      .q_keys  (q_keys_r),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    hold_nxt      = hold_r;
    start_nxt     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      kcsm_pkg::FSM_IDLE: begin
        if (accept) begin
          if (is_query) begin
            start_nxt = 1'b1;
            state_nxt = kcsm_pkg::FSM_SCAN;
          end else begin
            out_nxt.found       = 1'b0;
            out_nxt.found_entry = '0;
            out_nxt.status      = kcsm_pkg::ST_OK;
            case (in_data.kind)
              kcsm_pkg::KIND_HEADER: begin
                if (!entry_ok) begin
                  out_nxt.status = kcsm_pkg::ST_BAD_ENTRY;
                end else if (!count_ok) begin
                  out_nxt.status = kcsm_pkg::ST_BAD_COUNT;
                end
              end
              kcsm_pkg::KIND_KEY: begin
                if (!entry_ok) begin
                  out_nxt.status = kcsm_pkg::ST_BAD_ENTRY;
                end else if (!slot_ok) begin
                  out_nxt.status = kcsm_pkg::ST_BAD_SLOT;
                end
              end
              default: ;
            endcase
            out_valid_nxt = 1'b1;
          end
        end
      end
      kcsm_pkg::FSM_SCAN: begin
        if (tok[ENTRIES].valid) begin
          hold_nxt.found       = tok[ENTRIES].found;
          hold_nxt.found_entry = tok[ENTRIES].found_entry;
          hold_nxt.status      = kcsm_pkg::ST_OK;
          if (out_free) begin
            out_nxt       = hold_nxt;
            out_valid_nxt = 1'b1;
            state_nxt     = kcsm_pkg::FSM_IDLE;
          end else begin
            state_nxt = kcsm_pkg::FSM_WAIT;
          end
        end
      end
      kcsm_pkg::FSM_WAIT: begin
        if (out_free) begin
          out_nxt       = hold_r;
          out_valid_nxt = 1'b1;
          state_nxt     = kcsm_pkg::FSM_IDLE;
        end
      end
      default: state_nxt = kcsm_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kcsm_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
    end
    out_r  <= out_nxt;
    hold_r <= hold_nxt;
    if (accept && is_query) begin
      q_count_r <= in_data.count;
      q_keys_r  <= {in_data.pressed_5, in_data.pressed_4, in_data.pressed_3,
                    in_data.pressed_2, in_data.pressed_1, in_data.pressed_0};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
